// ===== design/cvba_pkg.sv =====
// ----------------------------------------------------------------------------
// cvba_pkg: shared definitions for the contiguous video memory allocator
// Pool sizes, field widths, operation and status codes, and the command
// structures that pass between the sequencer, the flag store and the scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package cvba_pkg;

	// Pool sizes in blocks.
	localparam int TILE_POOL_BLOCKS = 8;
	localparam int MAP_POOL_BLOCKS  = 16;
	localparam int POOL_MAX_BLOCKS  =
		(TILE_POOL_BLOCKS > MAP_POOL_BLOCKS) ? TILE_POOL_BLOCKS : MAP_POOL_BLOCKS;

	// Index widths into each pool and a count wide enough to hold a pool size.
	localparam int TILE_IDX_W = (TILE_POOL_BLOCKS > 1) ? $clog2(TILE_POOL_BLOCKS) : 1;
	localparam int MAP_IDX_W  = (MAP_POOL_BLOCKS > 1) ? $clog2(MAP_POOL_BLOCKS) : 1;
	localparam int CNT_W      = $clog2(POOL_MAX_BLOCKS + 1);

	// Range arithmetic width: holds base plus count of a release and a pool size.
	localparam int RANGE_W = (CNT_W + 1 > 6) ? CNT_W + 1 : 6;

	// Field widths.
	localparam int OP_W      = 2;
	localparam int BYTES_W   = 16;
	localparam int RBASE_W   = 4;
	localparam int RCOUNT_W  = 5;
	localparam int STATUS_W  = 2;
	localparam int BASE_W    = 4;
	localparam int BCOUNT_W  = 5;
	localparam int TBANKS_W  = 4;
	localparam int MBANKS_W  = 5;

	// Block geometry.
	localparam int TILE_BLOCK_SHIFT = 14;
	localparam int MAP_BLOCK_SHIFT  = 11;
	localparam logic [BYTES_W:0] TILE_MAX_BYTES = 17'd16384;
	localparam int MAPS_PER_TILE_SHIFT = 3;

	// Register reset values.
	localparam logic [TBANKS_W-1:0] RESET_TILE_BANKS = 4'd8;
	localparam logic [MBANKS_W-1:0] RESET_MAP_BANKS  = 5'd16;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd2;

	// Pool selector.
	localparam logic POOL_TILE = 1'b0;
	localparam logic POOL_MAP  = 1'b1;

	// Register select, taken from the word address bit.
	localparam logic REG_TILE_BANKS = 1'b0;
	localparam logic REG_MAP_BANKS  = 1'b1;

	// Command to the flag store.
	typedef struct packed {
		logic               init;
		logic               set;
		logic               clr;
		logic               pool;
		logic [RANGE_W-1:0] lo;
		logic [RANGE_W-1:0] hi;
		logic [RANGE_W-1:0] reserve;
	} flag_cmd_t;

	// Command to the run scanner.
	typedef struct packed {
		logic               start;
		logic               step;
		logic [RANGE_W-1:0] len;
		logic [CNT_W-1:0]   size;
	} scan_cmd_t;

	// Scanner report for the current block.
	typedef struct packed {
		logic             hit;
		logic             last;
		logic [CNT_W-1:0] first;
	} scan_res_t;

	// Tile flags with the lowest reserve blocks set.
	function automatic logic [TILE_POOL_BLOCKS-1:0] reserve_mask(
		input logic [RANGE_W-1:0] reserve
	);
		logic [TILE_POOL_BLOCKS-1:0] m;
		m = '0;
		for (int i = 0; i < TILE_POOL_BLOCKS; i++) begin
			m[i] = (RANGE_W'(i) < reserve);
		end
		return m;
	endfunction

	// Number of tile blocks that hold the map blocks: ceil(map_banks / 8).
	function automatic logic [RANGE_W-1:0] map_reserve(input logic [MBANKS_W-1:0] banks);
		logic [RANGE_W-1:0] sum;
		sum = RANGE_W'(banks) + RANGE_W'(7);
		return sum >> MAPS_PER_TILE_SHIFT;
	endfunction

endpackage

`default_nettype wire

// ===== design/contiguous_vram_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// contiguous_vram_block_allocator_top: first-fit video memory block allocator
// Sequencer, configuration registers and stream ports around the flag store
// and the run scanner for one screen's tile and map pools.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | contents
//  s_*      | in        | s_tvalid / s_tready  | one request: op, pool, size, release span
//  m_*      | out       | m_tvalid / m_tready  | one result: status, base, block count
//  apb      | in        | psel, penable, pready| tile_banks at 0x0, map_banks at 0x4
//
// Init, release, invalid size and an over-long run go from acceptance to the done
// state, then to the output register. An allocate first walks the scanner over
// the block flags, up to the active pool size (at most 16), and no new request is
// taken meanwhile. A result waiting on m_tready holds the block in its done
// state. Reset sets both registers and reserves the map tiles at once.
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_vram_block_allocator_top (
	input  wire         clk,
	input  wire         arst_n,
	// Request stream.
	input  wire         s_tvalid,
	output logic        s_tready,
	// Bits up from 0: request_bytes[15:0], release_base[19:16],
	// release_count[24:20], zero [31:25].
	input  wire  [31:0] s_tdata,
	// Bits up from 0: op[1:0], pool[2].
	input  wire  [2:0]  s_tuser,
	// Result stream.
	output logic        m_tvalid,
	input  wire         m_tready,
	// Bits up from 0: base[3:0], block_count[8:4], zero [15:9].
	output logic [15:0] m_tdata,
	// Bits up from 0: status[1:0].
	output logic [1:0]  m_tuser,
	// Configuration port.
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int RW = cvba_pkg::RANGE_W;
	localparam int CW = cvba_pkg::CNT_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;

	logic [cvba_pkg::TBANKS_W-1:0] tile_banks_q;
	logic [cvba_pkg::MBANKS_W-1:0] map_banks_q;

	logic                            pool_q;
	logic [RW-1:0]                   len_q;
	logic [CW-1:0]                   size_q;
	logic [cvba_pkg::STATUS_W-1:0]   res_status_q;
	logic [cvba_pkg::BASE_W-1:0]     res_base_q;
	logic [cvba_pkg::BCOUNT_W-1:0]   res_count_q;

	logic                            m_tvalid_q;
	logic [cvba_pkg::STATUS_W-1:0]   out_status_q;
	logic [cvba_pkg::BASE_W-1:0]     out_base_q;
	logic [cvba_pkg::BCOUNT_W-1:0]   out_count_q;

	// Request fields.
	logic [cvba_pkg::OP_W-1:0]     in_op;
	logic                          in_pool;
	logic [cvba_pkg::BYTES_W-1:0]  in_bytes;
	logic [cvba_pkg::RBASE_W-1:0]  in_rbase;
	logic [cvba_pkg::RCOUNT_W-1:0] in_rcount;

	assign in_op     = s_tuser[1:0];
	assign in_pool   = s_tuser[2];
	assign in_bytes  = s_tdata[15:0];
	assign in_rbase  = s_tdata[19:16];
	assign in_rcount = s_tdata[24:20];

	logic s_accept;
	logic out_load;
	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// Active pool sizes, limited by the physical pools.
	logic [RW-1:0] tile_size;
	logic [RW-1:0] map_size;
	logic [RW-1:0] pool_size;
	always_comb begin
		tile_size = (RW'(tile_banks_q) < RW'(cvba_pkg::TILE_POOL_BLOCKS)) ?
			RW'(tile_banks_q) : RW'(cvba_pkg::TILE_POOL_BLOCKS);
		map_size  = (RW'(map_banks_q) < RW'(cvba_pkg::MAP_POOL_BLOCKS)) ?
			RW'(map_banks_q) : RW'(cvba_pkg::MAP_POOL_BLOCKS);
		pool_size = (in_pool == cvba_pkg::POOL_MAP) ? map_size : tile_size;
	end

	// Allocation size check and block count with ceiling.
	logic                         bad_size;
	logic [cvba_pkg::BYTES_W-1:0] bytes_m1;
	logic [cvba_pkg::BYTES_W-1:0] blocks_m1;
	logic [RW-1:0]                req_len;
	logic                         too_long;
	always_comb begin
		bad_size  = (in_bytes == '0) || ((in_pool == cvba_pkg::POOL_TILE) &&
			({1'b0, in_bytes} > cvba_pkg::TILE_MAX_BYTES));
		bytes_m1  = in_bytes - cvba_pkg::BYTES_W'(1);
		blocks_m1 = (in_pool == cvba_pkg::POOL_MAP) ?
			(bytes_m1 >> cvba_pkg::MAP_BLOCK_SHIFT) :
			(bytes_m1 >> cvba_pkg::TILE_BLOCK_SHIFT);
		req_len   = RW'(blocks_m1) + RW'(1);
		too_long  = (req_len > pool_size);
	end

	// Release span clipped to the active pool.
	logic [RW-1:0] rel_end;
	logic [RW-1:0] rel_lim;
	logic [RW-1:0] rel_count;
	always_comb begin
		rel_end   = RW'(in_rbase) + RW'(in_rcount);
		rel_lim   = (rel_end < pool_size) ? rel_end : pool_size;
		rel_count = (rel_lim > RW'(in_rbase)) ? (rel_lim - RW'(in_rbase)) : '0;
	end

	// Shared scanner and flag store.
	cvba_pkg::scan_cmd_t scan_cmd;
	cvba_pkg::scan_res_t scan_res;
	cvba_pkg::flag_cmd_t flag_cmd;
	logic [CW-1:0]       scan_idx;
	logic                flag_free;
	logic                scan_hit;

	assign scan_hit = (state_q == ST_SCAN) && scan_res.hit;

	always_comb begin
		scan_cmd.start = s_accept;
		scan_cmd.step  = (state_q == ST_SCAN);
		scan_cmd.len   = len_q;
		scan_cmd.size  = size_q;
	end

	always_comb begin
		flag_cmd.init    = s_accept && (in_op == cvba_pkg::OP_INIT);
		flag_cmd.clr     = s_accept && (in_op == cvba_pkg::OP_RELEASE);
		flag_cmd.set     = scan_hit;
		flag_cmd.reserve = cvba_pkg::map_reserve(map_banks_q);
		if (scan_hit) begin
			flag_cmd.pool = pool_q;
			flag_cmd.lo   = RW'(scan_res.first);
			flag_cmd.hi   = RW'(scan_idx) + RW'(1);
		end else begin
			flag_cmd.pool = in_pool;
			flag_cmd.lo   = RW'(in_rbase);
			flag_cmd.hi   = rel_lim;
		end
	end

	cvba_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (scan_cmd),
		.flag_free (flag_free),
		.idx       (scan_idx),
		.res       (scan_res)
	);

	cvba_flags u_flags (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (flag_cmd),
		.rd_pool (pool_q),
		.rd_idx  (scan_idx),
		.rd_free (flag_free)
	);

	// Sequencer and result capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						if ((in_op == cvba_pkg::OP_ALLOC) && !bad_size && !too_long) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (scan_res.hit || scan_res.last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Per-request operands and the pending result.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			pool_q       <= in_pool;
			len_q        <= req_len;
			size_q       <= pool_size[CW-1:0];
			res_status_q <= cvba_pkg::ST_OK;
			res_base_q   <= '0;
			res_count_q  <= '0;
			case (in_op)
				cvba_pkg::OP_ALLOC: begin
					if (bad_size) begin
						res_status_q <= cvba_pkg::ST_BAD_SIZE;
					end else if (too_long) begin
						res_status_q <= cvba_pkg::ST_NO_SPACE;
					end
				end
				cvba_pkg::OP_RELEASE: begin
					res_count_q <= rel_count[cvba_pkg::BCOUNT_W-1:0];
				end
				default: begin
					res_count_q <= '0;
				end
			endcase
		end else if (state_q == ST_SCAN) begin
			if (scan_res.hit) begin
				res_base_q  <= scan_res.first[cvba_pkg::BASE_W-1:0];
				res_count_q <= len_q[cvba_pkg::BCOUNT_W-1:0];
			end else if (scan_res.last) begin
				res_status_q <= cvba_pkg::ST_NO_SPACE;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_base_q   <= res_base_q;
			out_count_q  <= res_count_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {7'd0, out_count_q, out_base_q};

	// Configuration registers.
	logic cfg_write;
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_banks_q <= cvba_pkg::RESET_TILE_BANKS;
			map_banks_q  <= cvba_pkg::RESET_MAP_BANKS;
		end else if (cfg_write) begin
			if (paddr[2] == cvba_pkg::REG_MAP_BANKS) begin
				map_banks_q <= pwdata[cvba_pkg::MBANKS_W-1:0];
			end else begin
				tile_banks_q <= pwdata[cvba_pkg::TBANKS_W-1:0];
			end
		end
	end

	// Register read back; the byte lane bits of the address are ignored.
	always_comb begin
		if (paddr[2] == cvba_pkg::REG_TILE_BANKS) begin
			prdata = {28'd0, tile_banks_q};
		end else begin
			prdata = {27'd0, map_banks_q};
		end
	end

`ifndef SYNTHESIS
	// A request is taken only from idle, so the next cycle is never ready.
	assert property (@(posedge clk) disable iff (!arst_n) s_accept |=> !s_tready)
		else $error("request taken while an earlier one was still in progress");

	// The scanner cursor stays inside the active pool.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_idx < size_q))
		else $error("scan cursor ran past the active pool");

	// A run is only completed on a free block.
	assert property (@(posedge clk) disable iff (!arst_n) scan_hit |-> flag_free)
		else $error("run completed on a used block");
`endif

endmodule

`default_nettype wire

// ===== design/cvba_flags.sv =====
// ----------------------------------------------------------------------------
// cvba_flags: used flags of the tile pool and the map pool
// Holds one flag per block, sets or clears a block range in one register
// update, and reads back one flag of the selected pool for the scanner.
// ----------------------------------------------------------------------------
`default_nettype none

module cvba_flags (
	input  wire                         clk,
	input  wire                         arst_n,
	input  cvba_pkg::flag_cmd_t         cmd,
	input  wire                         rd_pool,
	input  wire  [cvba_pkg::CNT_W-1:0]  rd_idx,
	output logic                        rd_free
);

	logic [cvba_pkg::TILE_POOL_BLOCKS-1:0] tile_used_q;
	logic [cvba_pkg::MAP_POOL_BLOCKS-1:0]  map_used_q;
	logic [cvba_pkg::TILE_POOL_BLOCKS-1:0] tile_range;
	logic [cvba_pkg::MAP_POOL_BLOCKS-1:0]  map_range;

	// Range masks for the half-open span lo..hi.
	always_comb begin
		for (int i = 0; i < cvba_pkg::TILE_POOL_BLOCKS; i++) begin
			tile_range[i] = (cvba_pkg::RANGE_W'(i) >= cmd.lo) &&
				(cvba_pkg::RANGE_W'(i) < cmd.hi);
		end
		for (int i = 0; i < cvba_pkg::MAP_POOL_BLOCKS; i++) begin
			map_range[i] = (cvba_pkg::RANGE_W'(i) >= cmd.lo) &&
				(cvba_pkg::RANGE_W'(i) < cmd.hi);
		end
	end

	// Flag update: init, range set after a hit, range clear on release.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_used_q <= cvba_pkg::reserve_mask(
				cvba_pkg::map_reserve(cvba_pkg::RESET_MAP_BANKS));
			map_used_q  <= '0;
		end else if (cmd.init) begin
			tile_used_q <= cvba_pkg::reserve_mask(cmd.reserve);
			map_used_q  <= '0;
		end else if (cmd.set) begin
			if (cmd.pool == cvba_pkg::POOL_MAP) begin
				map_used_q <= map_used_q | map_range;
			end else begin
				tile_used_q <= tile_used_q | tile_range;
			end
		end else if (cmd.clr) begin
			if (cmd.pool == cvba_pkg::POOL_MAP) begin
				map_used_q <= map_used_q & ~map_range;
			end else begin
				tile_used_q <= tile_used_q & ~tile_range;
			end
		end
	end

	// One flag of the selected pool.
	always_comb begin
		if (rd_pool == cvba_pkg::POOL_MAP) begin
			rd_free = !map_used_q[rd_idx[cvba_pkg::MAP_IDX_W-1:0]];
		end else begin
			rd_free = !tile_used_q[rd_idx[cvba_pkg::TILE_IDX_W-1:0]];
		end
	end

endmodule

`default_nettype wire

// ===== design/cvba_scan.sv =====
// ----------------------------------------------------------------------------
// cvba_scan: first-fit run scanner
// Walks the pool one block flag per cycle, counting the current run of free
// blocks, and reports when the run reaches the requested length.
// ----------------------------------------------------------------------------
`default_nettype none

module cvba_scan (
	input  wire                         clk,
	input  wire                         arst_n,
	input  cvba_pkg::scan_cmd_t         cmd,
	input  wire                         flag_free,
	output logic [cvba_pkg::CNT_W-1:0]  idx,
	output cvba_pkg::scan_res_t         res
);

	logic [cvba_pkg::CNT_W-1:0] idx_q;
	logic [cvba_pkg::CNT_W-1:0] run_q;
	logic [cvba_pkg::CNT_W-1:0] first_q;
	logic [cvba_pkg::RANGE_W-1:0] run_next;

	assign idx      = idx_q;
	assign run_next = cvba_pkg::RANGE_W'(run_q) + cvba_pkg::RANGE_W'(1);

	// Report for the block under the cursor.
	always_comb begin
		res.hit   = flag_free && (run_next == cmd.len);
		res.last  = (idx_q == cmd.size - cvba_pkg::CNT_W'(1));
		res.first = (run_q == '0) ? idx_q : first_q;
	end

	// Cursor and run tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			run_q   <= '0;
			first_q <= '0;
		end else if (cmd.start) begin
			idx_q <= '0;
			run_q <= '0;
		end else if (cmd.step) begin
			idx_q <= idx_q + cvba_pkg::CNT_W'(1);
			if (flag_free) begin
				run_q <= run_next[cvba_pkg::CNT_W-1:0];
				if (run_q == '0) begin
					first_q <= idx_q;
				end
			end else begin
				run_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire
